@@ hdl/blwe_pkg.sv @@
`timescale 1ns / 1ps

package blwe_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;

  localparam int REQ_W  = 3;
  localparam int POS_W  = 7;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 7;

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CMP_A  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int CMP_W  = (CMP_A > POS_W) ? CMP_A : POS_W;

  localparam int GRP_SIZE = 8;
  localparam int NGRP     = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;

  localparam logic [CFG_W-1:0] MAX_RESET = CFG_W'(64);

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INSERT_AT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REMOVE_AT  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ_AT    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd5;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                op;
    logic [ADDR_W-1:0]       pos;
    logic [DATA_WIDTH-1:0]   value;
    logic [ADDR_W-1:0]       rd_pos;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_TAP,
    S_RD_GRP
  } state_t;

  function automatic logic [DATA_WIDTH-1:0] word_to_data(input logic [WORD_W-1:0] w);
    logic [63:0] tmp;
    tmp = 64'(w);
    return tmp[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] data_to_word(input logic [DATA_WIDTH-1:0] d);
    logic [63:0] tmp;
    tmp = 64'(d);
    return tmp[WORD_W-1:0];
  endfunction

endpackage

@@ hdl/blwe_req_if.sv @@
`timescale 1ns / 1ps

interface blwe_req_if
  import blwe_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [POS_W-1:0]  position;
  logic [WORD_W-1:0] entry_value;

  modport source (output valid, output req_type, output position, output entry_value,
                  input ready);
  modport sink (input valid, input req_type, input position, input entry_value,
                output ready);
endinterface

@@ hdl/blwe_rsp_if.sv @@
`timescale 1ns / 1ps

interface blwe_rsp_if
  import blwe_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [WORD_W-1:0] read_value;
  logic              read_valid;
  logic              evicted;
  logic [CFG_W-1:0]  count_after;

  modport source (output valid, output status, output read_value, output read_valid,
                  output evicted, output count_after, input ready);
  modport sink (input valid, input status, input read_value, input read_valid,
                input evicted, input count_after, output ready);
endinterface

@@ hdl/blwe_cell.sv @@
`timescale 1ns / 1ps

module blwe_cell
  import blwe_pkg::*;
(
  input  logic                  clk,
  input  logic [ADDR_W-1:0]     idx,
  input  cell_cmd_t             cmd,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] tap_o
);

  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic [DATA_WIDTH-1:0] tap_r, tap_nxt;

  always_comb begin
    data_nxt = data_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (idx > cmd.pos) begin
          data_nxt = left_data;
        end else if (idx == cmd.pos) begin
          data_nxt = cmd.value;
        end
      end
      CELL_REMOVE: begin
        if (idx >= cmd.pos) begin
          data_nxt = right_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  assign tap_nxt = (idx == cmd.rd_pos) ? data_r : '0;

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    tap_r  <= tap_nxt;
  end

  assign data_o = data_r;
  assign tap_o  = tap_r;

endmodule

@@ hdl/blwe_read_tree.sv @@
`timescale 1ns / 1ps

module blwe_read_tree
  import blwe_pkg::*;
(
  input  logic                  clk,
  input  logic [DATA_WIDTH-1:0] taps [DEPTH],
  output logic [DATA_WIDTH-1:0] word_o
);

  logic [DATA_WIDTH-1:0] grp_r   [NGRP];
  logic [DATA_WIDTH-1:0] grp_nxt [NGRP];

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
    end
    for (int j = 0; j < DEPTH; j++) begin
      grp_nxt[j / GRP_SIZE] = grp_nxt[j / GRP_SIZE] | taps[j];
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      grp_r[g] <= grp_nxt[g];
    end
  end

  always_comb begin
    word_o = '0;
    for (int g = 0; g < NGRP; g++) begin
      word_o = word_o | grp_r[g];
    end
  end

endmodule

@@ hdl/bounded_list_with_eviction.sv @@
`timescale 1ns / 1ps
// Timing: push, pop, insert, remove, clear and rejected requests: result beat in
//   the cycle after the request beat; a successful read_at: registered in turn in
//   the tap, group OR and output registers. Flow: one request in flight; none is
//   taken while a read_at runs through the two-stage OR tree or a result is not taken.
// Reset (rst_n low, synchronous): entry count 0, capacity 64, no result pending;
//   cell contents are not cleared.

module bounded_list_with_eviction
  import blwe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  blwe_req_if.sink         in_req,
  blwe_rsp_if.source       out_rsp,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [CFG_W-1:0]  max_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  state_t            state_r, state_nxt;

  logic              out_valid_r;
  status_t           out_status_r, out_status_nxt;
  logic [WORD_W-1:0] out_value_r, out_value_nxt;
  logic              out_rvalid_r, out_rvalid_nxt;
  logic              out_evict_r, out_evict_nxt;
  logic [CFG_W-1:0]  out_count_r, out_count_nxt;

  logic              accept;
  logic              in_ready;
  logic              rd_finish;
  logic              rd_start;
  logic              out_load;

  logic [CMP_W-1:0]  cnt_x, pos_x, cap_x;
  cell_cmd_t         cmd;
  status_t           dec_status;
  logic [WORD_W-1:0] dec_value;
  logic              dec_rvalid;
  logic              dec_evict;
  logic [CNT_W-1:0]  dec_count;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_tap  [DEPTH];
  logic [DATA_WIDTH-1:0] rd_word;

  assign accept = in_req.valid && in_ready;

  // capacity clamp
  always_comb begin
    if (max_r == '0) begin
      cap_x = CMP_W'(1);
    end else if (CMP_W'(max_r) > CMP_W'(DEPTH)) begin
      cap_x = CMP_W'(DEPTH);
    end else begin
      cap_x = CMP_W'(max_r);
    end
  end

  assign cnt_x = CMP_W'(count_r);
  assign pos_x = CMP_W'(in_req.position);

  always_comb begin
    cmd.op     = CELL_HOLD;
    cmd.pos    = '0;
    cmd.value  = word_to_data(in_req.entry_value);
    cmd.rd_pos = pos_x[ADDR_W-1:0];
    dec_status = ST_OK;
    dec_value  = '0;
    dec_rvalid = 1'b0;
    dec_evict  = 1'b0;
    dec_count  = count_r;
    rd_start   = 1'b0;
    case (in_req.req_type)
      REQ_PUSH_FRONT: begin
        cmd.op = CELL_INSERT;
        if (cnt_x >= cap_x) begin
          dec_evict = 1'b1;
          dec_count = CNT_W'(cap_x);
        end else begin
          dec_count = CNT_W'(cnt_x + CMP_W'(1));
        end
      end
      REQ_POP_FRONT: begin
        if (cnt_x == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          cmd.op     = CELL_REMOVE;
          dec_value  = data_to_word(cell_data[0]);
          dec_rvalid = 1'b1;
          dec_count  = CNT_W'(cnt_x - CMP_W'(1));
        end
      end
      REQ_INSERT_AT: begin
        if (pos_x > cnt_x) begin
          dec_status = ST_BADPOS;
        end else if (cnt_x >= cap_x) begin
          dec_status = ST_FULL;
        end else begin
          cmd.op    = CELL_INSERT;
          cmd.pos   = pos_x[ADDR_W-1:0];
          dec_count = CNT_W'(cnt_x + CMP_W'(1));
        end
      end
      REQ_REMOVE_AT: begin
        if (cnt_x == '0) begin
          dec_status = ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          dec_status = ST_BADPOS;
        end else begin
          cmd.op    = CELL_REMOVE;
          cmd.pos   = pos_x[ADDR_W-1:0];
          dec_count = CNT_W'(cnt_x - CMP_W'(1));
        end
      end
      REQ_READ_AT: begin
        if (pos_x >= cnt_x) begin
          dec_status = ST_BADPOS;
        end else begin
          rd_start = 1'b1;
        end
      end
      REQ_CLEAR: begin
        dec_count = '0;
      end
      default: begin
        dec_status = ST_BADPOS;
      end
    endcase
    if (!accept) begin
      cmd.op = CELL_HOLD;
    end
  end

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w, right_w;
      if (i == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_mid_r
        assign right_w = cell_data[i+1];
      end
      blwe_cell u_cell (
        .clk        (clk),
        .idx        (ADDR_W'(i)),
        .cmd        (cmd),
        .left_data  (left_w),
        .right_data (right_w),
        .data_o     (cell_data[i]),
        .tap_o      (cell_tap[i])
      );
    end
  endgenerate

  blwe_read_tree u_read_tree (
    .clk    (clk),
    .taps   (cell_tap),
    .word_o (rd_word)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && rd_start) begin
          state_nxt = S_RD_TAP;
        end
      end
      S_RD_TAP: begin
        state_nxt = S_RD_GRP;
      end
      S_RD_GRP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    rd_finish = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = !out_valid_r || out_rsp.ready;
      end
      S_RD_GRP: begin
        rd_finish = 1'b1;
      end
      default: begin
        in_ready  = 1'b0;
        rd_finish = 1'b0;
      end
    endcase
  end

  assign count_nxt = accept ? dec_count : count_r;
  assign out_load  = (accept && !rd_start) || rd_finish;

  always_comb begin
    if (rd_finish) begin
      out_status_nxt = ST_OK;
      out_value_nxt  = data_to_word(rd_word);
      out_rvalid_nxt = 1'b1;
      out_evict_nxt  = 1'b0;
      out_count_nxt  = CFG_W'(count_r);
    end else begin
      out_status_nxt = dec_status;
      out_value_nxt  = dec_value;
      out_rvalid_nxt = dec_rvalid;
      out_evict_nxt  = dec_evict;
      out_count_nxt  = CFG_W'(dec_count);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= MAX_RESET;
      count_r     <= '0;
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
      count_r <= count_nxt;
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_value_r  <= out_value_nxt;
      out_rvalid_r <= out_rvalid_nxt;
      out_evict_r  <= out_evict_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

  assign in_req.ready        = in_ready;
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.read_value  = out_value_r;
  assign out_rsp.read_valid  = out_rvalid_r;
  assign out_rsp.evicted     = out_evict_r;
  assign out_rsp.count_after = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(DEPTH))
    else $error("entry count beyond depth");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && rd_start) |-> ##3 (out_valid_r && out_rvalid_r))
    else $error("read result missing three cycles after request");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && dec_evict) |=> (CMP_W'(count_r) == $past(cap_x)))
    else $error("eviction did not leave the list at capacity");

  a_rvalid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rvalid_r) |-> (out_status_r == ST_OK))
    else $error("read data with error status");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && rd_start) |=> !in_ready ##1 !in_ready)
    else $error("request taken during read");

endmodule
